[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and defaults of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // field widths
    localparam int ADDR_W = 48;
    localparam int SIZE_W = 32;
    localparam int BS_W   = 17;
    localparam int STAT_W = 2;

    // defaults
    localparam int MAX_ORDER_DEF = 10;
    localparam logic [BS_W-1:0] BS_RESET = BS_W'(4096);

    // response status codes
    localparam logic [STAT_W-1:0] RSP_OK      = 2'd0;
    localparam logic [STAT_W-1:0] RSP_NOFREE  = 2'd1;
    localparam logic [STAT_W-1:0] RSP_BADADDR = 2'd2;

    // request action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // tree node status
    typedef enum logic [1:0] {
        ND_OUT   = 2'd0,
        ND_SPLIT = 2'd1,
        ND_ALLOC = 2'd2,
        ND_FREE  = 2'd3
    } node_st_t;

endpackage

[rtl/bba_intf.sv]
// ----------------------------------------------------------------------------
// bba request and response channels
// Valid/ready channels that carry allocator requests and responses.
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] request_size;
    logic [47:0] free_address;

    modport source (output valid, action, request_size, free_address, input ready);
    modport sink   (input valid, action, request_size, free_address, output ready);
endinterface

interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [47:0] block_address;
    logic [1:0]  status;

    modport source (output valid, block_address, status, input ready);
    modport sink   (input valid, block_address, status, output ready);
endinterface

[rtl/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2047
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/buddy_block_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a binary tree of 2^MAX_ORDER base blocks, with per
// level LIFO free lists linked through a node link RAM.
// ----------------------------------------------------------------------------
// Allocate finds the order and the lowest level with a free block, then pops
//   and splits down to that order and forms the address; free range checks,
//   takes MAX_ORDER divide steps, looks up the node, merges buddies and pushes.
// Throughput: one request at a time; a new request is taken only in idle.
// Reset: a clearing pass writes every node of both RAMs;
//   no request is taken during it, configuration writes are.
module buddy_block_allocator #(
    parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    bba_req_if.sink            req,
    bba_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    import bba_pkg::*;

    localparam int NW     = MAX_ORDER + 1;
    localparam int NODES  = (1 << NW) - 1;
    localparam int LEVELS = MAX_ORDER + 1;
    localparam int LVW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int RW     = BS_W + MAX_ORDER;
    localparam int CMPW   = (RW > SIZE_W) ? RW : SIZE_W;
    localparam int LW     = NW + 1;
    localparam logic [NW-1:0] LEAF_FIRST = NW'((1 << MAX_ORDER) - 1);
    localparam logic [NW-1:0] NODE_LAST  = NW'(NODES - 1);
    localparam logic [NW-1:0] NODE_NONE  = {NW{1'b1}};
    localparam logic [LVW-1:0] LVL_TOP   = LVW'(MAX_ORDER);

    typedef enum logic [24:0] {
        ST_CLR    = 25'h0000001,
        ST_IDLE   = 25'h0000002,
        ST_ASIZE  = 25'h0000004,
        ST_AFIND  = 25'h0000008,
        ST_SRD    = 25'h0000010,
        ST_SWR    = 25'h0000020,
        ST_SP1    = 25'h0000040,
        ST_SP2    = 25'h0000080,
        ST_AMUL   = 25'h0000100,
        ST_AADD   = 25'h0000200,
        ST_FCHK   = 25'h0000400,
        ST_FDIV   = 25'h0000800,
        ST_FEND   = 25'h0001000,
        ST_FLOOK  = 25'h0002000,
        ST_FLOOKW = 25'h0004000,
        ST_FMERGE = 25'h0008000,
        ST_FSIBW  = 25'h0010000,
        ST_UPOPW  = 25'h0020000,
        ST_URD    = 25'h0040000,
        ST_URDW   = 25'h0080000,
        ST_UFIXW  = 25'h0100000,
        ST_UDONE  = 25'h0200000,
        ST_MOUT2  = 25'h0400000,
        ST_FFINAL = 25'h0800000,
        ST_RESP   = 25'h1000000
    } state_t;

    // link entry: valid flag and next node
    typedef struct packed {
        logic          ok;
        logic [NW-1:0] link;
    } link_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    base_reg;
    logic [BS_W-1:0]      bs_reg;
    logic [NW-1:0]        head_reg [LEVELS];
    logic [NW-1:0]        head_next [LEVELS];
    logic                 hok_reg [LEVELS];
    logic                 hok_next [LEVELS];
    logic [LVW-1:0]       lvl_reg, lvl_next;
    logic [NW-1:0]        n_reg, n_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [ADDR_W-1:0]    faddr_reg, faddr_next;
    logic [LVW-1:0]       want_reg, want_next;
    logic [NW-1:0]        sib_reg, sib_next;
    logic [NW-1:0]        cur_reg, cur_next;
    logic [NW-1:0]        prev_reg, prev_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [MAX_ORDER-1:0] q_reg, q_next;
    logic [LVW-1:0]       divi_reg, divi_next;
    logic [MAX_ORDER-1:0] ord_reg, ord_next;
    logic [RW-1:0]        prod_reg, prod_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic [STAT_W-1:0]    res_st_reg, res_st_next;
    logic [ADDR_W-1:0]    rsp_addr_reg, rsp_addr_next;
    logic [STAT_W-1:0]    rsp_st_reg, rsp_st_next;

    // RAM ports
    logic                 st_we;
    logic [NW-1:0]        st_waddr, st_raddr;
    node_st_t             st_wdata;
    logic [1:0]           st_rdata;
    logic                 ln_we;
    logic [NW-1:0]        ln_waddr, ln_raddr;
    link_t                ln_wdata, ln_rdata;

    logic [BS_W-1:0]      bs_eff;
    logic [ADDR_W-1:0]    span;
    logic [RW-1:0]        div_step;
    logic [NW-1:0]        first;
    logic [NW-1:0]        sib_calc;
    logic                 cfg_wr;

    bba_ram #(.WIDTH(2), .DEPTH(NODES)) u_status_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    bba_ram #(.WIDTH(LW), .DEPTH(NODES)) u_link_ram (
        .clk   (clk),
        .we    (ln_we),
        .waddr (ln_waddr),
        .wdata (ln_wdata),
        .raddr (ln_raddr),
        .rdata (ln_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = paddr[3] ? 64'(bs_reg) : 64'(base_reg);

    // handshakes and response payload
    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.block_address = rsp_addr_reg;
    assign rsp.status        = rsp_st_reg;

    // derived values
    assign bs_eff   = (bs_reg == '0) ? BS_W'(1) : bs_reg;
    assign span     = faddr_reg - base_reg;
    assign div_step = RW'(bs_eff) << divi_reg;
    assign first    = (NW'(1) << (LVL_TOP - want_reg)) - NW'(1);
    assign sib_calc = n_reg[0] ? (n_reg + NW'(1)) : (n_reg - NW'(1));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        hok_next       = hok_reg;
        lvl_next       = lvl_reg;
        n_next         = n_reg;
        rsp_valid_next = rsp_valid_reg;
        size_next      = size_reg;
        faddr_next     = faddr_reg;
        want_next      = want_reg;
        sib_next       = sib_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        divi_next      = divi_reg;
        ord_next       = ord_reg;
        prod_next      = prod_reg;
        res_addr_next  = res_addr_reg;
        res_st_next    = res_st_reg;
        rsp_addr_next  = rsp_addr_reg;
        rsp_st_next    = rsp_st_reg;
        st_we          = 1'b0;
        st_waddr       = n_reg;
        st_wdata       = ND_OUT;
        st_raddr       = n_reg;
        ln_we          = 1'b0;
        ln_waddr       = n_reg;
        ln_wdata       = '{ok: hok_reg[lvl_reg], link: head_reg[lvl_reg]};
        ln_raddr       = head_reg[lvl_reg];

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            // clear status and links, root alone is free
            ST_CLR:
            begin
                st_we    = 1'b1;
                st_wdata = (n_reg == '0) ? ND_FREE : ND_OUT;
                ln_we    = 1'b1;
                ln_wdata = '0;
                n_next   = n_reg + NW'(1);
                if (n_reg == NODE_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    size_next  = req.request_size;
                    faddr_next = req.free_address;
                    lvl_next   = '0;
                    state_next = (req.action == ACT_FREE) ? ST_FCHK : ST_ASIZE;
                end
            end
            // smallest order whose span holds the request
            ST_ASIZE:
            begin
                if (CMPW'(size_reg) <= (CMPW'(bs_eff) << lvl_reg))
                begin
                    want_next  = lvl_reg;
                    state_next = ST_AFIND;
                end
                else if (lvl_reg == LVL_TOP)
                begin
                    res_addr_next = '0;
                    res_st_next   = RSP_NOFREE;
                    state_next    = ST_RESP;
                end
                else
                begin
                    lvl_next = lvl_reg + LVW'(1);
                end
            end
            // lowest level with a free block
            ST_AFIND:
            begin
                if (hok_reg[lvl_reg])
                begin
                    state_next = ST_SRD;
                end
                else if (lvl_reg == LVL_TOP)
                begin
                    res_addr_next = '0;
                    res_st_next   = RSP_NOFREE;
                    state_next    = ST_RESP;
                end
                else
                begin
                    lvl_next = lvl_reg + LVW'(1);
                end
            end
            // pop the level head: read its link
            ST_SRD:
            begin
                ln_raddr   = head_reg[lvl_reg];
                n_next     = head_reg[lvl_reg];
                state_next = ST_SWR;
            end
            ST_SWR:
            begin
                head_next[lvl_reg] = ln_rdata.link;
                hok_next[lvl_reg]  = ln_rdata.ok;
                st_we              = 1'b1;
                if (lvl_reg == want_reg)
                begin
                    st_wdata   = ND_ALLOC;
                    ord_next   = MAX_ORDER'(n_reg - first) << want_reg;
                    state_next = ST_AMUL;
                end
                else
                begin
                    st_wdata   = ND_SPLIT;
                    lvl_next   = lvl_reg - LVW'(1);
                    state_next = ST_SP1;
                end
            end
            // push right child
            ST_SP1:
            begin
                st_we      = 1'b1;
                st_waddr   = n_reg + n_reg + NW'(2);
                st_wdata   = ND_FREE;
                ln_we      = 1'b1;
                ln_waddr   = n_reg + n_reg + NW'(2);
                state_next = ST_SP2;
            end
            // push left child
            ST_SP2:
            begin
                st_we              = 1'b1;
                st_waddr           = n_reg + n_reg + NW'(1);
                st_wdata           = ND_FREE;
                ln_we              = 1'b1;
                ln_waddr           = n_reg + n_reg + NW'(1);
                ln_wdata           = '{ok: 1'b1, link: n_reg + n_reg + NW'(2)};
                head_next[lvl_reg] = n_reg + n_reg + NW'(1);
                hok_next[lvl_reg]  = 1'b1;
                state_next         = ST_SRD;
            end
            ST_AMUL:
            begin
                prod_next  = RW'(ord_reg) * RW'(bs_eff);
                state_next = ST_AADD;
            end
            ST_AADD:
            begin
                res_addr_next = base_reg + ADDR_W'(prod_reg);
                res_st_next   = RSP_OK;
                state_next    = ST_RESP;
            end
            // free: range checks before the divide
            ST_FCHK:
            begin
                if ((faddr_reg < base_reg) ||
                    (span >= (ADDR_W'(bs_eff) << MAX_ORDER)))
                begin
                    res_addr_next = '0;
                    res_st_next   = RSP_BADADDR;
                    state_next    = ST_RESP;
                end
                else
                begin
                    rem_next   = span[RW-1:0];
                    q_next     = '0;
                    divi_next  = LVW'(MAX_ORDER - 1);
                    state_next = ST_FDIV;
                end
            end
            // restoring divide, one quotient bit a cycle
            ST_FDIV:
            begin
                if (rem_reg >= div_step)
                begin
                    rem_next = rem_reg - div_step;
                    q_next   = (q_reg << 1) | MAX_ORDER'(1);
                end
                else
                begin
                    q_next = q_reg << 1;
                end
                if (divi_reg == '0)
                begin
                    state_next = ST_FEND;
                end
                else
                begin
                    divi_next = divi_reg - LVW'(1);
                end
            end
            ST_FEND:
            begin
                if (rem_reg != '0)
                begin
                    res_addr_next = '0;
                    res_st_next   = RSP_BADADDR;
                    state_next    = ST_RESP;
                end
                else
                begin
                    n_next     = LEAF_FIRST + NW'(q_reg);
                    lvl_next   = '0;
                    state_next = ST_FLOOK;
                end
            end
            ST_FLOOK:
            begin
                st_raddr   = n_reg;
                state_next = ST_FLOOKW;
            end
            // climb left edges until a live node
            ST_FLOOKW:
            begin
                if (st_rdata == ND_OUT)
                begin
                    if (!n_reg[0])
                    begin
                        res_addr_next = '0;
                        res_st_next   = RSP_BADADDR;
                        state_next    = ST_RESP;
                    end
                    else
                    begin
                        n_next     = (n_reg - NW'(1)) >> 1;
                        lvl_next   = lvl_reg + LVW'(1);
                        state_next = ST_FLOOK;
                    end
                end
                else if (st_rdata != ND_ALLOC)
                begin
                    res_addr_next = '0;
                    res_st_next   = RSP_BADADDR;
                    state_next    = ST_RESP;
                end
                else
                begin
                    state_next = ST_FMERGE;
                end
            end
            ST_FMERGE:
            begin
                if (n_reg == '0)
                begin
                    state_next = ST_FFINAL;
                end
                else
                begin
                    sib_next   = sib_calc;
                    st_raddr   = sib_calc;
                    state_next = ST_FSIBW;
                end
            end
            // buddy free: unlink it from its list
            ST_FSIBW:
            begin
                if (st_rdata != ND_FREE)
                begin
                    state_next = ST_FFINAL;
                end
                else if (!hok_reg[lvl_reg])
                begin
                    state_next = ST_UDONE;
                end
                else if (head_reg[lvl_reg] == sib_reg)
                begin
                    ln_raddr   = sib_reg;
                    state_next = ST_UPOPW;
                end
                else
                begin
                    cur_next   = head_reg[lvl_reg];
                    state_next = ST_URD;
                end
            end
            ST_UPOPW:
            begin
                head_next[lvl_reg] = ln_rdata.link;
                hok_next[lvl_reg]  = ln_rdata.ok;
                state_next         = ST_UDONE;
            end
            ST_URD:
            begin
                ln_raddr   = cur_reg;
                state_next = ST_URDW;
            end
            ST_URDW:
            begin
                if (!ln_rdata.ok)
                begin
                    state_next = ST_UDONE;
                end
                else if (ln_rdata.link == sib_reg)
                begin
                    prev_next  = cur_reg;
                    ln_raddr   = sib_reg;
                    state_next = ST_UFIXW;
                end
                else
                begin
                    cur_next   = ln_rdata.link;
                    state_next = (ln_rdata.link == NODE_NONE) ? ST_UDONE : ST_URD;
                end
            end
            // bypass the buddy in the list
            ST_UFIXW:
            begin
                ln_we      = 1'b1;
                ln_waddr   = prev_reg;
                ln_wdata   = ln_rdata;
                state_next = ST_UDONE;
            end
            ST_UDONE:
            begin
                st_we      = 1'b1;
                st_waddr   = n_reg;
                st_wdata   = ND_OUT;
                state_next = ST_MOUT2;
            end
            ST_MOUT2:
            begin
                st_we      = 1'b1;
                st_waddr   = sib_reg;
                st_wdata   = ND_OUT;
                n_next     = (n_reg - NW'(1)) >> 1;
                lvl_next   = lvl_reg + LVW'(1);
                state_next = ST_FMERGE;
            end
            // mark merged block free and push it
            ST_FFINAL:
            begin
                st_we              = 1'b1;
                st_waddr           = n_reg;
                st_wdata           = ND_FREE;
                ln_we              = 1'b1;
                ln_waddr           = n_reg;
                head_next[lvl_reg] = n_reg;
                hok_next[lvl_reg]  = 1'b1;
                res_addr_next      = '0;
                res_st_next        = RSP_OK;
                state_next         = ST_RESP;
            end
            // hand result to the output register
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_addr_next  = res_addr_reg;
                    rsp_st_next    = res_st_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            lvl_reg       <= '0;
            n_reg         <= '0;
            rsp_valid_reg <= 1'b0;
            base_reg      <= '0;
            bs_reg        <= BS_RESET;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                hok_reg[i]  <= (i == MAX_ORDER);
            end
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            n_reg         <= n_next;
            rsp_valid_reg <= rsp_valid_next;
            head_reg      <= head_next;
            hok_reg       <= hok_next;
            if (cfg_wr)
            begin
                if (paddr[3])
                begin
                    bs_reg <= pwdata[BS_W-1:0];
                end
                else
                begin
                    base_reg <= pwdata[ADDR_W-1:0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        size_reg     <= size_next;
        faddr_reg    <= faddr_next;
        want_reg     <= want_next;
        sib_reg      <= sib_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        divi_reg     <= divi_next;
        ord_reg      <= ord_next;
        prod_reg     <= prod_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        rsp_addr_reg <= rsp_addr_next;
        rsp_st_reg   <= rsp_st_next;
    end

`ifndef NO_ASSERTIONS
    a_rsp_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_st_reg == RSP_OK || rsp_st_reg == RSP_NOFREE ||
                           rsp_st_reg == RSP_BADADDR))
        else $error("response status out of range");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_st_reg != RSP_OK) |-> (rsp_addr_reg == '0))
        else $error("failed response carries an address");
    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= LVL_TOP)
        else $error("level index beyond top");
    a_req_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start");
`endif

endmodule
